FILE: sv/avcc2ab_pkg.sv
// ----------------------------------------------------------------------------
// avcc2ab_pkg
// shared types and constants for the decoder configuration record to
// annex-b parameter set converter
// ----------------------------------------------------------------------------
package avcc2ab_pkg;

  localparam int unsigned MaxResults = 5;
  localparam int unsigned HdrSkip    = 5;
  localparam logic [7:0]  SpsCntMask = 8'h1f;
  localparam logic [7:0]  StartCode [4] = '{8'h00, 8'h00, 8'h00, 8'h01};

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       unit_is_pps;
    logic       unit_end;
    logic       unit_drop;
    logic       record_done;
    logic       run_last;
  } item_t;

  typedef struct packed {
    logic [2:0]                  count;
    item_t [MaxResults-1:0]      items;
  } burst_t;

endpackage

FILE: sv/avcc2ab_parse.sv
// ----------------------------------------------------------------------------
// avcc2ab_parse
// record parser state and the burst of result beats caused by one input beat
// ----------------------------------------------------------------------------
module avcc2ab_parse (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_fire,
  input  logic [7:0]           data_byte,
  input  logic                 record_last,
  output avcc2ab_pkg::burst_t  burst
);
  import avcc2ab_pkg::*;

  localparam logic [2:0] PH_HDR    = 3'd0;
  localparam logic [2:0] PH_SPSCNT = 3'd1;
  localparam logic [2:0] PH_LENHI  = 3'd2;
  localparam logic [2:0] PH_LENLO  = 3'd3;
  localparam logic [2:0] PH_BODY   = 3'd4;
  localparam logic [2:0] PH_PPSCNT = 3'd5;
  localparam logic [2:0] PH_DONE   = 3'd6;

  logic [2:0]  phase, phase_next;
  logic [2:0]  skip_count, skip_count_next;
  logic [7:0]  units_left, units_left_next;
  logic [7:0]  length_high, length_high_next;
  logic [15:0] body_left, body_left_next;
  logic        in_pps_list, in_pps_list_next;
  logic        finished, finished_next;

  logic        sc_emit, sc_end, body_emit, unit_done, fin, status_add;
  logic [15:0] body_len, body_dec;
  logic [2:0]  n_main, n_all;
  item_t       status_item;

  always_comb begin
    phase_next       = phase;
    skip_count_next  = skip_count;
    units_left_next  = units_left;
    length_high_next = length_high;
    body_left_next   = body_left;
    in_pps_list_next = in_pps_list;
    finished_next    = finished;
    sc_emit   = 1'b0;
    sc_end    = 1'b0;
    body_emit = 1'b0;
    unit_done = 1'b0;
    fin       = 1'b0;
    body_len  = {length_high, data_byte};
    body_dec  = body_left - 16'd1;

    if (!finished) begin
      unique case (phase)
        PH_HDR: begin
          skip_count_next = skip_count + 3'd1;
          if (skip_count_next >= 3'(HdrSkip)) phase_next = PH_SPSCNT;
        end
        PH_SPSCNT: begin
          units_left_next  = data_byte & SpsCntMask;
          in_pps_list_next = 1'b0;
          phase_next = (units_left_next == 8'd0) ? PH_PPSCNT : PH_LENHI;
        end
        PH_PPSCNT: begin
          units_left_next  = data_byte;
          in_pps_list_next = 1'b1;
          if (data_byte == 8'd0) fin = 1'b1;
          else phase_next = PH_LENHI;
        end
        PH_LENHI: begin
          length_high_next = data_byte;
          phase_next       = PH_LENLO;
        end
        PH_LENLO: begin
          body_left_next = body_len;
          sc_emit        = 1'b1;
          sc_end         = (body_len == 16'd0);
          if (body_len == 16'd0) unit_done = 1'b1;
          else phase_next = PH_BODY;
        end
        PH_BODY: begin
          body_left_next = body_dec;
          body_emit      = 1'b1;
          if (body_dec == 16'd0) unit_done = 1'b1;
        end
        default: begin
          finished_next = 1'b1;
          phase_next    = PH_DONE;
        end
      endcase
    end

    if (unit_done) begin
      units_left_next = units_left - 8'd1;
      if (units_left_next != 8'd0) phase_next = PH_LENHI;
      else if (in_pps_list) fin = 1'b1;
      else phase_next = PH_PPSCNT;
    end

    if (fin) begin
      finished_next = 1'b1;
      phase_next    = PH_DONE;
    end
  end

  always_comb begin
    status_add = record_last && !finished && !finished_next;
    n_main = sc_emit ? 3'd4 : ((body_emit || fin) ? 3'd1 : 3'd0);
    n_all  = n_main + {2'b00, status_add};

    status_item             = '0;
    status_item.unit_is_pps = in_pps_list_next;
    status_item.unit_drop   = (phase_next == PH_BODY);
    status_item.record_done = 1'b1;

    burst.count = n_all;
    burst.items = '0;
    for (int i = 0; i < MaxResults; i++) begin
      burst.items[i].unit_is_pps = in_pps_list_next;
    end
    if (sc_emit) begin
      for (int i = 0; i < 4; i++) begin
        burst.items[i].out_byte   = StartCode[i];
        burst.items[i].byte_valid = 1'b1;
      end
      burst.items[3].unit_end = sc_end;
    end else if (body_emit) begin
      burst.items[0].out_byte   = data_byte;
      burst.items[0].byte_valid = 1'b1;
      burst.items[0].unit_end   = (body_dec == 16'd0);
    end
    for (int i = 0; i < MaxResults; i++) begin
      if (fin && 3'(i) == n_main - 3'd1) burst.items[i].record_done = 1'b1;
      if (status_add && 3'(i) == n_main) burst.items[i] = status_item;
    end
    for (int i = 0; i < MaxResults; i++) begin
      if (n_all != 3'd0 && 3'(i) == n_all - 3'd1) burst.items[i].run_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (in_fire && record_last)) begin
      phase       <= PH_HDR;
      skip_count  <= '0;
      units_left  <= '0;
      length_high <= '0;
      body_left   <= '0;
      in_pps_list <= 1'b0;
      finished    <= 1'b0;
    end else if (in_fire) begin
      phase       <= phase_next;
      skip_count  <= skip_count_next;
      units_left  <= units_left_next;
      length_high <= length_high_next;
      body_left   <= body_left_next;
      in_pps_list <= in_pps_list_next;
      finished    <= finished_next;
    end
  end

endmodule

FILE: sv/avcc2ab_outq.sv
// ----------------------------------------------------------------------------
// avcc2ab_outq
// result register for one burst, handed out one beat per cycle while out_ready
// ----------------------------------------------------------------------------
module avcc2ab_outq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_fire,
  input  avcc2ab_pkg::burst_t  burst,
  output logic                 can_load,
  output logic                 out_valid,
  input  logic                 out_ready,
  output avcc2ab_pkg::item_t   head
);
  import avcc2ab_pkg::*;

  item_t [MaxResults-1:0] slots;
  logic [2:0]             idx;
  logic                   busy;
  logic                   take, last_take;

  assign head      = slots[idx];
  assign out_valid = busy;
  assign take      = busy && out_ready;
  assign last_take = take && head.run_last;
  assign can_load  = !busy || last_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (in_fire && burst.count != 3'd0) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (last_take) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (take) begin
      idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && burst.count != 3'd0) begin
      slots <= burst.items;
    end
  end

endmodule

FILE: sv/avcc_to_annexb_param_sets_core.sv
// ----------------------------------------------------------------------------
// avcc_to_annexb_param_sets_core
// decoder configuration record in, annex-b parameter sets out
// first result beat: shown in the cycle after the input beat is taken
// throughput: one input beat per cycle with out_ready high while each gives
// at most one result; a unit opener gives four or five, holding input that long
// reset: parser back to header skip, result register emptied
// ----------------------------------------------------------------------------
module avcc_to_annexb_param_sets_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       record_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       unit_is_pps,
  output logic       unit_end,
  output logic       unit_drop,
  output logic       record_done,
  output logic       run_last
);
  import avcc2ab_pkg::*;

  burst_t burst;
  item_t  head;
  logic   in_fire;

  assign in_fire = in_valid && in_ready;

  avcc2ab_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .in_fire     (in_fire),
    .data_byte   (data_byte),
    .record_last (record_last),
    .burst       (burst)
  );

  avcc2ab_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .burst     (burst),
    .can_load  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_byte    = head.out_byte;
  assign byte_valid  = head.byte_valid;
  assign unit_is_pps = head.unit_is_pps;
  assign unit_end    = head.unit_end;
  assign unit_drop   = head.unit_drop;
  assign record_done = head.record_done;
  assign run_last    = head.run_last;

  a_burst_shows: assert property (@(posedge clk) disable iff (rst)
    in_fire && burst.count != 3'd0 |=> out_valid)
    else $error("burst not presented");

  a_drop_is_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && unit_drop |-> !byte_valid && record_done)
    else $error("drop beat malformed");

  a_done_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && record_done |-> run_last)
    else $error("record done not on last beat");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output busy after reset");

endmodule
